### hw/rtl/htmv_pkg.sv
// htmv_pkg: shared types and constants for the hit time match veto unit.
// Holds command, kind and register index codes and the reset values.
// No dependencies.
package htmv_pkg;

	// input command codes, carried in s_tuser
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_HIT   = 2'd1,
		CMD_END   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// result kind codes, carried in m_tuser
	typedef enum logic {
		KIND_MATCH   = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_PRIO_LOW   = 3'd0,
		REG_PRIO_HIGH  = 3'd1,
		REG_SEL_THR    = 3'd2,
		REG_NOISY_0A   = 3'd3,
		REG_NOISY_0B   = 3'd4,
		REG_NOISY_1A   = 3'd5,
		REG_NOISY_1B   = 3'd6,
		REG_UNUSED     = 3'd7
	} reg_idx_t;

	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned OUT_DATA_W = 112;

	localparam logic [31:0] PRIO_LOW_RST  = 32'd3681723712;
	localparam logic [31:0] PRIO_HIGH_RST = 32'd4186171073;
	localparam logic [3:0]  SEL_THR_RST   = 4'd9;
	localparam logic [12:0] NOISY_RST     = 13'h1FFF;

	// best delta when no matched hit seen yet: 999 ns in 1/32 ns units
	localparam logic signed [24:0] NO_DELTA = 25'sd31968;

	// cap on match records per detector per event
	localparam logic [7:0] MAX_MATCHED = 8'd128;

	localparam logic [15:0] HIT_CNT_MAX = 16'hFFFF;

endpackage

### hw/rtl/hit_time_match_veto_unit.sv
// hit_time_match_veto_unit: time matching of two-detector hits against an
// event reference time, with noisy channel skip and edge priority selection.
// Each input word is held in the input register; its result word, if any, is then
// registered in the result register before it leaves on the result stream.
// Throughput: one input word per cycle; s_tready drops only while the input
// register and the result register both hold a word and m_tready is low.
// Reset (arst_n low, asynchronous): config registers take their defaults,
// event state is cleared, both stages empty.
// Depends on htmv_pkg.
module hit_time_match_veto_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata: detector[0], edge_mask[4:1], channel[16:5], stamp[40:17], zero fill
	input  logic [htmv_pkg::IN_DATA_W-1:0]      s_tdata,
	// s_tuser: command[1:0]
	input  logic [1:0]                          s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata: which_detector[0], hit_index[16:1], matched_channel[28:17],
	// match_flags[30:29], best_priority_a[34:31], best_priority_b[38:35],
	// best_delta_a[63:39], best_delta_b[88:64], count_a[96:89],
	// count_b[104:97], zero fill
	output logic [htmv_pkg::OUT_DATA_W-1:0]     m_tdata,
	// m_tuser: kind[0]
	output logic                                m_tuser,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [2:0]                          cfg_index,
	input  logic [31:0]                         cfg_data
);
	import htmv_pkg::*;

	// config registers
	logic [31:0]        prio_low_q, prio_high_q;
	logic [3:0]         sel_thr_q;
	logic [12:0]        noisy_q [4];

	// event state
	logic signed [23:0] ref_time_q;
	logic [3:0]         best_prio_q [2];
	logic signed [24:0] best_delta_q [2];
	logic [7:0]         match_cnt_q [2];
	logic [15:0]        hit_cnt_q [2];

	// input stage
	logic               valid_s1;
	logic [1:0]         cmd_s1;
	logic               det_s1;
	logic [3:0]         emask_s1;
	logic [11:0]        chan_s1;
	logic signed [23:0] stamp_s1;

	// result register
	logic               out_valid_q;
	logic               out_kind_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// datapath
	logic               adv;
	logic [63:0]        prio_tbl;
	logic [3:0]         prio;
	logic [1:0]         nz_a_idx, nz_b_idx;
	logic               noisy;
	logic               selected;
	logic               under_cap;
	logic               rec_fire;
	logic               sum_fire;
	logic signed [24:0] dt;
	logic [24:0]        mag_dt, mag_best;
	logic [1:0]         flags;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

	// hit evaluation: noisy check, priority lookup, time difference
	always_comb begin
		prio_tbl  = {prio_high_q, prio_low_q};
		prio      = prio_tbl[{emask_s1, 2'b00} +: 4];
		nz_a_idx  = {det_s1, 1'b0};
		nz_b_idx  = {det_s1, 1'b1};
		noisy     = (!noisy_q[nz_a_idx][12] && noisy_q[nz_a_idx][11:0] == chan_s1) ||
		            (!noisy_q[nz_b_idx][12] && noisy_q[nz_b_idx][11:0] == chan_s1);
		selected  = prio >= sel_thr_q;
		under_cap = match_cnt_q[det_s1] < MAX_MATCHED;
		dt        = {stamp_s1[23], stamp_s1} - {ref_time_q[23], ref_time_q};
		mag_dt    = dt[24] ? 25'(-dt) : dt;
		mag_best  = best_delta_q[det_s1][24] ? 25'(-best_delta_q[det_s1])
		                                     : best_delta_q[det_s1];
		rec_fire  = (cmd_s1 == CMD_HIT) && !noisy && selected && under_cap;
		sum_fire  = (cmd_s1 == CMD_END);
		flags     = {best_prio_q[1] >= sel_thr_q, best_prio_q[0] >= sel_thr_q};
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_low_q  <= PRIO_LOW_RST;
			prio_high_q <= PRIO_HIGH_RST;
			sel_thr_q   <= SEL_THR_RST;
			for (int i = 0; i < 4; i++) noisy_q[i] <= NOISY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PRIO_LOW:  prio_low_q  <= cfg_data;
				REG_PRIO_HIGH: prio_high_q <= cfg_data;
				REG_SEL_THR:   sel_thr_q   <= cfg_data[3:0];
				REG_NOISY_0A:  noisy_q[0]  <= cfg_data[12:0];
				REG_NOISY_0B:  noisy_q[1]  <= cfg_data[12:0];
				REG_NOISY_1A:  noisy_q[2]  <= cfg_data[12:0];
				REG_NOISY_1B:  noisy_q[3]  <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// input stage: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage: payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= s_tuser;
			det_s1   <= s_tdata[0];
			emask_s1 <= s_tdata[4:1];
			chan_s1  <= s_tdata[16:5];
			stamp_s1 <= s_tdata[40:17];
		end
	end

	// event state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_time_q <= '0;
			for (int d = 0; d < 2; d++) begin
				best_prio_q[d]  <= '0;
				best_delta_q[d] <= NO_DELTA;
				match_cnt_q[d]  <= '0;
				hit_cnt_q[d]    <= '0;
			end
		end else if (adv) begin
			case (cmd_s1)
				CMD_START: begin
					ref_time_q <= stamp_s1;
					for (int d = 0; d < 2; d++) begin
						best_prio_q[d]  <= '0;
						best_delta_q[d] <= NO_DELTA;
						match_cnt_q[d]  <= '0;
						hit_cnt_q[d]    <= '0;
					end
				end
				CMD_HIT: begin
					if (hit_cnt_q[det_s1] != HIT_CNT_MAX)
						hit_cnt_q[det_s1] <= hit_cnt_q[det_s1] + 16'd1;
					if (!noisy) begin
						if (prio > best_prio_q[det_s1]) best_prio_q[det_s1] <= prio;
						if (selected && mag_dt < mag_best) best_delta_q[det_s1] <= dt;
						if (selected && under_cap)
							match_cnt_q[det_s1] <= match_cnt_q[det_s1] + 8'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= rec_fire || sum_fire;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (adv && rec_fire) begin
			out_kind_q <= KIND_MATCH;
			out_data_q <= {83'd0, chan_s1, hit_cnt_q[det_s1], det_s1};
		end else if (adv && sum_fire) begin
			out_kind_q <= KIND_SUMMARY;
			out_data_q <= {7'd0, match_cnt_q[1], match_cnt_q[0],
			               best_delta_q[1], best_delta_q[0],
			               best_prio_q[1], best_prio_q[0], flags, 29'd0};
		end
	end

`ifndef NO_ASSERTIONS
	// record count never passes the cap
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		match_cnt_q[0] <= MAX_MATCHED && match_cnt_q[1] <= MAX_MATCHED)
		else $error("matched count above cap");

	// a held input stage with a stalled result blocks new input
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("input accepted while pipeline stalled");

	// a start word clears per-detector statistics
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_s1 == CMD_START |=> hit_cnt_q[0] == 16'd0 && hit_cnt_q[1] == 16'd0 &&
		best_prio_q[0] == 4'd0 && best_prio_q[1] == 4'd0)
		else $error("start word did not clear event state");

	// best priority only grows on hits
	a_prio: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_s1 == CMD_HIT |=> best_prio_q[0] >= $past(best_prio_q[0]) &&
		best_prio_q[1] >= $past(best_prio_q[1]))
		else $error("best priority decreased on a hit");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for hit_time_match_veto_unit, predicting each match
// record and event summary from its own model of the event state and config registers.
// Depends on htmv_pkg and the hit_time_match_veto_unit RTL.
module testbench;

	import htmv_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	// result word layout, highest field first
	typedef struct packed {
		logic [6:0]         fill;
		logic [7:0]         count_b;
		logic [7:0]         count_a;
		logic signed [24:0] delta_b;
		logic signed [24:0] delta_a;
		logic [3:0]         prio_b;
		logic [3:0]         prio_a;
		logic [1:0]         flags;
		logic [11:0]        chan;
		logic [15:0]        hit_index;
		logic               det;
	} result_word_t;

	typedef struct packed {
		kind_t        kind;
		result_word_t w;
	} veto_record_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [2:0]            cfg_index = '0;
	logic [31:0]           cfg_data = '0;

	// model of the config registers
	logic [31:0] prio_low, prio_high;
	logic [3:0]  sel_thr;
	logic [12:0] noisy [4];

	// model of the event state
	logic signed [23:0] ref_time;
	logic [3:0]         best_prio [2];
	logic signed [24:0] best_delta [2];
	logic [7:0]         match_cnt [2];
	logic [15:0]        hit_cnt [2];

	veto_record_t record_q [$];
	logic [11:0]  hot_chan [4];
	bit           steady = 1'b0;
	int           errors = 0;
	int           quiet_cycles = 0;

	hit_time_match_veto_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// receiver stalls at random unless the steady stretch is on
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 6);
	end

	function automatic void clear_event_state();
		int d;
		for (d = 0; d < 2; d++) begin
			best_prio[d]  = '0;
			best_delta[d] = NO_DELTA;
			match_cnt[d]  = '0;
			hit_cnt[d]    = '0;
		end
	endfunction

	task automatic reset_model();
		prio_low  = PRIO_LOW_RST;
		prio_high = PRIO_HIGH_RST;
		sel_thr   = SEL_THR_RST;
		noisy     = '{NOISY_RST, NOISY_RST, NOISY_RST, NOISY_RST};
		ref_time  = '0;
		clear_event_state();
	endtask

	// advance the event state by one input word; returns 1 when a result word is due
	function automatic bit veto_step(input cmd_t cmd, input logic det, input logic [3:0] mask,
			input logic [11:0] chan, input logic signed [23:0] stamp,
			output veto_record_t rec);
		logic [15:0] idx;
		logic [31:0] word;
		logic [3:0]  prio;
		bit          skip;
		int          dt, dt_mag, best_mag;
		rec = '0;
		veto_step = 1'b0;
		case (cmd)
			CMD_START: begin
				ref_time = stamp;
				clear_event_state();
			end
			CMD_HIT: begin
				idx = hit_cnt[det];
				if (hit_cnt[det] != HIT_CNT_MAX)
					hit_cnt[det] = hit_cnt[det] + 16'd1;
				// negative noisy values never match a channel
				skip = (!noisy[{det, 1'b0}][12] && noisy[{det, 1'b0}][11:0] == chan) ||
					(!noisy[{det, 1'b1}][12] && noisy[{det, 1'b1}][11:0] == chan);
				if (!skip) begin
					word = mask[3] ? prio_high : prio_low;
					prio = word[{mask[2:0], 2'b00} +: 4];
					if (prio > best_prio[det])
						best_prio[det] = prio;
					if (prio >= sel_thr) begin
						dt = int'(stamp) - int'(ref_time);
						dt_mag = (dt < 0) ? -dt : dt;
						best_mag = int'(best_delta[det]);
						best_mag = (best_mag < 0) ? -best_mag : best_mag;
						// strict compare: the earlier hit wins a tie
						if (dt_mag < best_mag)
							best_delta[det] = dt[24:0];
						if (match_cnt[det] < MAX_MATCHED) begin
							match_cnt[det] = match_cnt[det] + 8'd1;
							rec.kind        = KIND_MATCH;
							rec.w.det       = det;
							rec.w.hit_index = idx;
							rec.w.chan      = chan;
							veto_step = 1'b1;
						end
					end
				end
			end
			CMD_END: begin
				rec.kind      = KIND_SUMMARY;
				rec.w.flags   = {best_prio[1] >= sel_thr, best_prio[0] >= sel_thr};
				rec.w.prio_a  = best_prio[0];
				rec.w.prio_b  = best_prio[1];
				rec.w.delta_a = best_delta[0];
				rec.w.delta_b = best_delta[1];
				rec.w.count_a = match_cnt[0];
				rec.w.count_b = match_cnt[1];
				veto_step = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// send one input word; called and returns at a falling edge, leaves tvalid high
	task automatic send_word(input cmd_t cmd, input logic det, input logic [3:0] mask,
			input logic [11:0] chan, input logic signed [23:0] stamp);
		veto_record_t rec;
		while (!steady && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'd0, stamp, chan, mask, det};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (veto_step(cmd, det, mask, chan, stamp, rec))
			record_q.push_back(rec);
		@(negedge clk);
	endtask

	// drop tvalid, wait for every pending result and let the pipeline empty
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (record_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_PRIO_LOW:  prio_low  = value;
			REG_PRIO_HIGH: prio_high = value;
			REG_SEL_THR:   sel_thr   = value[3:0];
			REG_NOISY_0A:  noisy[0]  = value[12:0];
			REG_NOISY_0B:  noisy[1]  = value[12:0];
			REG_NOISY_1A:  noisy[2]  = value[12:0];
			REG_NOISY_1B:  noisy[3]  = value[12:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// random junk above the register width half of the time
	function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
		logic [31:0] r;
		r = $urandom_range(1) ? 32'($urandom) : 32'd0;
		with_junk = (r << w) | v;
	endfunction

	task automatic load_config(input logic [31:0] plo, input logic [31:0] phi,
			input logic [3:0] thr, input logic [12:0] n0a, input logic [12:0] n0b,
			input logic [12:0] n1a, input logic [12:0] n1b);
		wait_idle();
		write_reg(REG_PRIO_LOW, plo);
		write_reg(REG_PRIO_HIGH, phi);
		write_reg(REG_SEL_THR, with_junk(thr, 4));
		write_reg(REG_NOISY_0A, with_junk(n0a, 13));
		write_reg(REG_NOISY_0B, with_junk(n0b, 13));
		write_reg(REG_NOISY_1A, with_junk(n1a, 13));
		write_reg(REG_NOISY_1B, with_junk(n1b, 13));
		cfg_valid <= 1'b0;
	endtask

	// unused, a negative value, or a real channel
	function automatic logic [12:0] pick_noisy();
		case ($urandom_range(3))
			0:       pick_noisy = NOISY_RST;
			1:       pick_noisy = {1'b1, 12'($urandom)};
			default: pick_noisy = {1'b0, 12'($urandom)};
		endcase
	endfunction

	function automatic logic [11:0] pick_channel();
		case ($urandom_range(7))
			0, 1:    pick_channel = hot_chan[$urandom_range(3)];
			2:       pick_channel = $urandom_range(1) ? 12'hFFF : 12'h000;
			default: pick_channel = 12'($urandom);
		endcase
	endfunction

	task automatic report(input string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	// compare each accepted result word with the oldest predicted one
	always @(posedge clk) begin : check_results
		veto_record_t want;
		result_word_t got;
		string        bad;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (record_q.size() == 0) begin
				report($sformatf("unexpected result word: kind=%0d data=%h", m_tuser, m_tdata));
			end else begin
				want = record_q.pop_front();
				bad = "";
				if (m_tuser !== want.kind) bad = {bad, " kind"};
				if (got.det !== want.w.det) bad = {bad, " which_detector"};
				if (got.hit_index !== want.w.hit_index) bad = {bad, " hit_index"};
				if (got.chan !== want.w.chan) bad = {bad, " matched_channel"};
				if (got.flags !== want.w.flags) bad = {bad, " match_flags"};
				if (got.prio_a !== want.w.prio_a) bad = {bad, " best_priority_a"};
				if (got.prio_b !== want.w.prio_b) bad = {bad, " best_priority_b"};
				if (got.delta_a !== want.w.delta_a) bad = {bad, " best_delta_a"};
				if (got.delta_b !== want.w.delta_b) bad = {bad, " best_delta_b"};
				if (got.count_a !== want.w.count_a) bad = {bad, " count_a"};
				if (got.count_b !== want.w.count_b) bad = {bad, " count_b"};
				if (got.fill !== want.w.fill) bad = {bad, " zero_fill"};
				if (bad != "")
					report($sformatf("mismatch in%s: expected kind=%0d data=%h, got kind=%0d data=%h",
						bad, want.kind, want.w, m_tuser, m_tdata));
			end
		end
	end

	// watchdog: too long without any word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// hits ahead of any start run on the reset state and default registers
	task automatic test_hit_before_start();
		send_word(CMD_HIT, 1'b0, 4'd3, 12'd7, 24'sd320);
		send_word(CMD_HIT, 1'b1, 4'd5, 12'd9, -24'sd64);
		send_word(CMD_END, 1'b1, 4'hF, 12'hFFF, 24'sd0);
	endtask

	// noisy channels, every edge mask, stamp extremes, ignored command, delta tie
	task automatic test_edge_cases();
		int m;
		load_config(PRIO_LOW_RST, PRIO_HIGH_RST, SEL_THR_RST, 13'd0, 13'd4095, NOISY_RST,
			13'd100);
		send_word(CMD_START, 1'b0, 4'd0, 12'd0, -24'sd8388608);
		send_word(CMD_HIT, 1'b0, 4'hF, 12'd0, 24'sd0);
		send_word(CMD_HIT, 1'b1, 4'hF, 12'd100, 24'sd0);
		send_word(CMD_HIT, 1'b1, 4'hF, 12'd0, -24'sd8388605);
		for (m = 0; m < 16; m++)
			send_word(CMD_HIT, m[0], m[3:0], (m == 14) ? 12'hFFF : 12'(m * 273),
				m[0] ? 24'sd8388607 : 24'(-8388608 + m));
		send_word(CMD_NONE, 1'b1, 4'hF, 12'hFFF, 24'sd8388607);
		send_word(CMD_END, 1'b0, 4'd0, 12'd0, 24'sd0);
		// equal magnitudes of opposite sign: the first one stays
		send_word(CMD_START, 1'b1, 4'hF, 12'hFFF, 24'sd0);
		send_word(CMD_HIT, 1'b0, 4'hF, 12'd1, 24'sd5);
		send_word(CMD_HIT, 1'b0, 4'hF, 12'd2, -24'sd5);
		send_word(CMD_END, 1'b0, 4'd0, 12'd0, 24'sd0);
	endtask

	// more matched hits than the cap: records stop, best delta keeps moving
	task automatic test_match_cap();
		int i;
		load_config(PRIO_LOW_RST, PRIO_HIGH_RST, 4'd0, NOISY_RST, NOISY_RST, NOISY_RST,
			NOISY_RST);
		send_word(CMD_START, 1'b0, 4'd0, 12'd0, 24'sd1000);
		for (i = 0; i < 140; i++)
			send_word(CMD_HIT, 1'b0, 4'($urandom), 12'($urandom), 24'(1200 - i));
		send_word(CMD_HIT, 1'b1, 4'($urandom), 12'($urandom), 24'($urandom));
		send_word(CMD_END, 1'b0, 4'd0, 12'd0, 24'sd0);
	endtask

	// one event with random content, now and then missing its start or end
	task automatic random_event(output int n);
		logic signed [23:0] base, stamp;
		int                 hits, i;
		n = 0;
		base = 24'($urandom);
		if ($urandom_range(9) != 0) begin
			send_word(CMD_START, 1'($urandom), 4'($urandom), 12'($urandom), base);
			n++;
		end
		hits = $urandom_range(20);
		for (i = 0; i < hits; i++) begin
			if ($urandom_range(4) == 0)
				stamp = 24'($urandom);
			else
				stamp = base + 24'($urandom_range(4000)) - 24'd2000;
			send_word(CMD_HIT, 1'($urandom), 4'($urandom), pick_channel(), stamp);
			n++;
		end
		if ($urandom_range(9) != 0) begin
			send_word(CMD_END, 1'($urandom), 4'($urandom), 12'($urandom), 24'($urandom));
			n++;
		end
	endtask

	task automatic test_random_traffic();
		logic [31:0] plo, phi;
		logic [3:0]  thr;
		logic [12:0] nz [4];
		int          phase, k, sent, n;
		for (phase = 0; phase < 8; phase++) begin
			plo = $urandom;
			phi = $urandom;
			thr = 4'($urandom);
			case (phase)
				0: begin
					plo = PRIO_LOW_RST;
					phi = PRIO_HIGH_RST;
					thr = SEL_THR_RST;
				end
				1: thr = 4'd0;
				2: thr = 4'd15;
				3: begin
					plo = 32'h0;
					phi = 32'h0;
				end
				4: begin
					plo = 32'hFFFF_FFFF;
					phi = 32'hFFFF_FFFF;
					thr = 4'd15;
				end
				default: ;
			endcase
			for (k = 0; k < 4; k++) begin
				nz[k] = pick_noisy();
				hot_chan[k] = nz[k][11:0];
			end
			load_config(plo, phi, thr, nz[0], nz[1], nz[2], nz[3]);
			steady = (phase == 5 || phase == 6);
			sent = 0;
			while (sent < 250) begin
				if ($urandom_range(99) < 85) begin
					random_event(n);
					sent += n;
				end else begin
					// stray word of any command
					send_word(cmd_t'($urandom_range(3)), 1'($urandom), 4'($urandom),
						pick_channel(), 24'($urandom));
					sent++;
				end
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		reset_model();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_hit_before_start();
		test_edge_cases();
		test_match_cap();
		test_random_traffic();
		wait_idle();
		repeat (8) @(negedge clk);
		if (errors == 0 && record_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
